FILE: rtl/mpts_pkg.sv
`timescale 1ns / 1ps
package mpts_pkg;

  // table geometry
  localparam int TASK_W = 6;
  localparam int TASKS  = 2 ** TASK_W;
  localparam int LVL_W  = 3;
  localparam int LEVELS = 2 ** LVL_W;
  localparam int POS_W  = TASK_W;
  localparam int CNT_W  = TASK_W + 1;
  localparam int RUN_W  = 4;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  // run state codes
  localparam logic [RUN_W-1:0] RUN_EXEC  = RUN_W'(0);
  localparam logic [RUN_W-1:0] RUN_READY = RUN_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_CHANGE  = 3'd2,
    CMD_SCHED   = 3'd3,
    CMD_BLOCK   = 3'd4,
    CMD_UNBLOCK = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_NO_CUR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_LOAD,
    S_UNLINK,
    S_DEC,
    S_APPEND,
    S_SCAN,
    S_RUN_RD,
    S_RUN_UPD,
    S_NEXT_RD,
    S_NEXT_UPD,
    S_DONE
  } state_t;

  // one slot memory word
  typedef struct packed {
    logic [RUN_W-1:0] run_state;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] position;
  } slot_t;

  // best candidate found so far during a decision scan
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] idx;
    logic [LVL_W-1:0]  level;
    logic [POS_W-1:0]  position;
  } best_t;

  // verdict of the compare unit on one slot
  typedef struct packed {
    logic better;
    logic shift;
  } cmp_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] p);
    return (32'(p) < LEVELS) ? p : LVL_W'(LEVELS - 1);
  endfunction

endpackage

FILE: rtl/mpts_if.sv
`timescale 1ns / 1ps
interface mpts_cmd_if;
  import mpts_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TASK_W-1:0]   task_id;
  logic [LVL_W-1:0]    priority_req;
  logic [RUN_W-1:0]    new_state;
  modport source (output valid, command, task_id, priority_req, new_state, input ready);
  modport sink   (input valid, command, task_id, priority_req, new_state, output ready);
endinterface

interface mpts_res_if;
  import mpts_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [TASK_W-1:0]   from_task;
  logic                prev_valid;
  logic [TASK_W-1:0]   to_task;
  logic                switched;
  modport source (output valid, status, from_task, prev_valid, to_task, switched,
                  input ready);
  modport sink   (input valid, status, from_task, prev_valid, to_task, switched,
                  output ready);
endinterface

interface mpts_cfg_if;
  import mpts_pkg::*;
  logic                valid;
  logic                ready;
  logic [TASK_W-1:0]   idle_slot_id;
  modport source (output valid, idle_slot_id, input ready);
  modport sink   (input valid, idle_slot_id, output ready);
endinterface

FILE: rtl/mpts_slot_ram.sv
`timescale 1ns / 1ps
module mpts_slot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mpts_cmp_unit.sv
`timescale 1ns / 1ps
module mpts_cmp_unit
  import mpts_pkg::*;
(
  input  slot_t            slot,
  input  logic             present,
  input  logic             self_hit,
  input  slot_t            tgt,
  input  best_t            best,
  output cmp_t             verdict,
  output logic [POS_W-1:0] pos_dec
);

  logic ready_slot;
  logic ahead;

  // candidate ordering: lower level first, then earlier queue position
  assign ready_slot = present && (slot.run_state == RUN_READY);
  assign ahead      = !best.valid || (slot.level < best.level) ||
                      ((slot.level == best.level) && (slot.position < best.position));

  assign verdict.better = ready_slot && ahead;

  // slots behind the one leaving its queue move up by one
  assign verdict.shift = present && !self_hit && (slot.level == tgt.level) &&
                         (slot.position > tgt.position);
  assign pos_dec       = slot.position - POS_W'(1);

endmodule

FILE: rtl/multilevel_priority_task_scheduler.sv
`timescale 1ns / 1ps
// Multilevel priority task scheduler. Holds a table of 64 task slots, each queued FIFO in one
// of 8 priority levels (level 0 most urgent), and takes one command beat at a time: add,
// remove, change level, schedule, block current, unblock. Every command returns exactly one
// result beat. Remove and change level walk the slot memory, since every slot behind the
// leaving one is renumbered; schedule, block and unblock walk all 64 slots to find the ready
// task. A refused or unused command, or a change to the same level, skips the walk. The
// walk reads one slot memory word per cycle through a single compare unit. cmd.ready is
// high only between commands; a finished result waits in its own register, so the next
// command can be taken while it is still unread. The idle_slot_id register is written
// through the cfg channel, which is always ready.
module multilevel_priority_task_scheduler
  import mpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mpts_cmd_if.sink   cmd,
  mpts_res_if.source res,
  mpts_cfg_if.sink   cfg
);

  state_t            state, state_next;

  // latched command
  logic [CMD_W-1:0]  req_cmd;
  logic [TASK_W-1:0] req_id;
  logic [LVL_W-1:0]  req_lvl;
  logic [RUN_W-1:0]  req_nst;

  // scheduler state
  logic [TASKS-1:0]  present;
  logic [CNT_W-1:0]  level_count [LEVELS];
  logic [TASK_W-1:0] running_task;
  logic              running_valid;
  logic [TASK_W-1:0] idle_slot;

  // walk control
  logic [TASK_W:0]   scan_cnt;
  logic              pend;
  logic [TASK_W-1:0] pend_idx;
  best_t             best;
  slot_t             tgt;

  // result being built and result register
  logic [STAT_W-1:0] status_r;
  logic [TASK_W-1:0] from_task_r;
  logic              prev_valid_r;
  logic              switched_r;
  logic              res_valid;
  logic [STAT_W-1:0] res_status;
  logic [TASK_W-1:0] res_from_task;
  logic              res_prev_valid;
  logic [TASK_W-1:0] res_to_task;
  logic              res_switched;

  // memory and unit wiring
  logic              mem_we;
  logic [TASK_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  logic [TASK_W-1:0] mem_raddr;
  slot_t             rdata;
  cmp_t              verdict;
  logic [POS_W-1:0]  pos_dec;
  logic [LVL_W-1:0]  cnt_idx;
  logic [CNT_W-1:0]  cnt_sel;
  logic              cur_exec;
  logic [TASK_W-1:0] next_sel;
  logic              scan_end;
  logic [STAT_W-1:0] dec_status;
  logic              res_load;

  mpts_slot_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  mpts_cmp_unit u_cmp (
    .slot     (rdata),
    .present  (present[pend_idx]),
    .self_hit (pend_idx == req_id),
    .tgt      (tgt),
    .best     (best),
    .verdict  (verdict),
    .pos_dec  (pos_dec)
  );

  // shared helpers
  assign scan_end = (scan_cnt == (TASK_W+1)'(TASKS));
  assign cnt_idx  = (state == S_DEC) ? tgt.level : req_lvl;
  assign cnt_sel  = level_count[cnt_idx];
  assign cur_exec = running_valid && present[running_task] && (rdata.run_state == RUN_EXEC);
  assign res_load = (state == S_DONE) && (!res_valid || res.ready);

  always_comb begin
    if (!best.valid) begin
      next_sel = idle_slot;
    end else if (cur_exec && (rdata.level < best.level)) begin
      next_sel = running_task;
    end else begin
      next_sel = best.idx;
    end
  end

  // early status from the latched command
  always_comb begin
    dec_status = STAT_OK;
    case (req_cmd)
      CMD_ADD: begin
        if (present[req_id]) dec_status = STAT_ABSENT;
      end
      CMD_REMOVE, CMD_CHANGE, CMD_UNBLOCK: begin
        if (!present[req_id]) dec_status = STAT_ABSENT;
      end
      CMD_BLOCK: begin
        if (!running_valid) dec_status = STAT_NO_CUR;
      end
      default: dec_status = STAT_OK;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (dec_status != STAT_OK) begin
          state_next = S_DONE;
        end else begin
          case (req_cmd)
            CMD_ADD:                                      state_next = S_APPEND;
            CMD_REMOVE, CMD_CHANGE, CMD_BLOCK, CMD_UNBLOCK: state_next = S_FETCH;
            CMD_SCHED:                                    state_next = S_SCAN;
            default:                                      state_next = S_DONE;
          endcase
        end
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD: begin
        if (req_cmd == CMD_BLOCK || req_cmd == CMD_UNBLOCK) begin
          state_next = S_SCAN;
        end else if (req_cmd == CMD_CHANGE && rdata.level == req_lvl) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        if (scan_end) state_next = S_DEC;
      end
      S_DEC:    state_next = (req_cmd == CMD_CHANGE) ? S_APPEND : S_DONE;
      S_APPEND: state_next = S_DONE;
      S_SCAN: begin
        if (scan_end) state_next = S_RUN_RD;
      end
      S_RUN_RD:   state_next = S_RUN_UPD;
      S_RUN_UPD:  state_next = S_NEXT_RD;
      S_NEXT_RD:  state_next = S_NEXT_UPD;
      S_NEXT_UPD: state_next = S_DONE;
      S_DONE: begin
        if (res_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_id;
    mem_wdata = rdata;
    mem_raddr = req_id;
    case (state)
      S_FETCH: begin
        mem_raddr = (req_cmd == CMD_BLOCK) ? running_task : req_id;
      end
      S_LOAD: begin
        if (req_cmd == CMD_BLOCK) begin
          mem_we              = present[running_task];
          mem_waddr           = running_task;
          mem_wdata.run_state = req_nst;
        end else if (req_cmd == CMD_UNBLOCK) begin
          mem_we              = 1'b1;
          mem_wdata.run_state = RUN_READY;
        end
      end
      S_UNLINK: begin
        mem_raddr          = scan_cnt[TASK_W-1:0];
        mem_we             = pend && verdict.shift;
        mem_waddr          = pend_idx;
        mem_wdata.position = pos_dec;
      end
      S_SCAN: begin
        mem_raddr = scan_cnt[TASK_W-1:0];
      end
      S_APPEND: begin
        mem_we              = 1'b1;
        mem_wdata.run_state = (req_cmd == CMD_ADD) ? RUN_READY : tgt.run_state;
        mem_wdata.level     = req_lvl;
        mem_wdata.position  = cnt_sel[POS_W-1:0];
      end
      S_RUN_RD: begin
        mem_raddr = running_task;
      end
      S_RUN_UPD: begin
        mem_we              = cur_exec;
        mem_waddr           = running_task;
        mem_wdata.run_state = RUN_READY;
      end
      S_NEXT_RD: begin
        mem_raddr = running_task;
      end
      S_NEXT_UPD: begin
        mem_we              = present[running_task] && (rdata.run_state == RUN_READY);
        mem_waddr           = running_task;
        mem_wdata.run_state = RUN_EXEC;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      present       <= '0;
      running_task  <= '0;
      running_valid <= 1'b0;
      idle_slot     <= '0;
      res_valid     <= 1'b0;
      for (int l = 0; l < LEVELS; l++) level_count[l] <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) idle_slot <= cfg.idle_slot_id;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_DEC: begin
          if (cnt_sel != '0) level_count[cnt_idx] <= cnt_sel - CNT_W'(1);
          if (req_cmd == CMD_REMOVE) present[req_id] <= 1'b0;
        end
        S_APPEND: begin
          level_count[cnt_idx] <= cnt_sel + CNT_W'(1);
          present[req_id]      <= 1'b1;
        end
        S_RUN_UPD: begin
          running_task  <= next_sel;
          running_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // walk counter and best candidate, kept until the decision is taken
  always_ff @(posedge clk) begin
    if (state == S_SCAN || state == S_UNLINK) begin
      if (!scan_end) scan_cnt <= scan_cnt + (TASK_W+1)'(1);
      pend     <= !scan_end;
      pend_idx <= scan_cnt[TASK_W-1:0];
      if (state == S_SCAN && pend && verdict.better) begin
        best.valid    <= 1'b1;
        best.idx      <= pend_idx;
        best.level    <= rdata.level;
        best.position <= rdata.position;
      end
    end else begin
      scan_cnt <= '0;
      pend     <= 1'b0;
      if (state == S_DECODE) best.valid <= 1'b0;
    end
  end

  // command latch and result fields
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      req_cmd      <= cmd.command;
      req_id       <= cmd.task_id;
      req_lvl      <= clamp_level(cmd.priority_req);
      req_nst      <= cmd.new_state;
      from_task_r  <= '0;
      prev_valid_r <= 1'b0;
      switched_r   <= 1'b0;
    end
    if (state == S_DECODE) status_r <= dec_status;
    if (state == S_LOAD) tgt <= rdata;
    if (state == S_RUN_UPD) begin
      from_task_r  <= running_task;
      prev_valid_r <= running_valid;
      switched_r   <= 1'b1;
    end
    if (res_load) begin
      res_status     <= status_r;
      res_from_task  <= from_task_r;
      res_prev_valid <= prev_valid_r;
      res_to_task    <= running_task;
      res_switched   <= switched_r;
    end
  end

  // ports
  assign cmd.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign res.valid      = res_valid;
  assign res.status     = res_status;
  assign res.from_task  = res_from_task;
  assign res.prev_valid = res_prev_valid;
  assign res.to_task    = res_to_task;
  assign res.switched   = res_switched;

endmodule

FILE: rtl/mpts_checker.sv
`timescale 1ns / 1ps
module mpts_checker
  import mpts_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [STAT_W-1:0] status,
  input logic [TASK_W-1:0] from_task,
  input logic              prev_valid,
  input logic              switched
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(switched))
    else $error("stalled result changed");

  // no decision means empty previous-task fields
  a_no_prev: assert property (@(posedge clk) disable iff (rst)
    res_valid && !switched |-> from_task == '0 && !prev_valid)
    else $error("previous task reported without a decision");

  // a refused command never makes a decision
  a_err_no_switch: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != STAT_OK |-> !switched)
    else $error("decision made on a refused command");

  // status code stays within its defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status == STAT_OK || status == STAT_ABSENT || status == STAT_NO_CUR)
    else $error("undefined status code");

endmodule

bind multilevel_priority_task_scheduler mpts_checker u_mpts_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .status     (res.status),
  .from_task  (res.from_task),
  .prev_valid (res.prev_valid),
  .switched   (res.switched)
);

FILE: dv/tb_multilevel_priority_task_scheduler.sv
`timescale 1ns / 1ps
module tb_multilevel_priority_task_scheduler;
  import mpts_pkg::*;

  localparam int SETTLE      = 100;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 275;

  // command codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TASK_W-1:0] task_id;
    logic [LVL_W-1:0]  priority_req;
    logic [RUN_W-1:0]  new_state;
    logic [3:0]        lead_gap;
    logic              drain_first;
  } command_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] from_task;
    logic              prev_valid;
    logic [TASK_W-1:0] to_task;
    logic              switched;
  } result_beat_t;

  logic clk;
  logic rst;

  mpts_cmd_if cmd_ch ();
  mpts_res_if res_ch ();
  mpts_cfg_if cfg_ch ();

  multilevel_priority_task_scheduler i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // scheduler image kept by the bench
  logic              slot_in_use [TASKS];
  logic [RUN_W-1:0]  slot_state  [TASKS];
  logic [LVL_W-1:0]  slot_lvl    [TASKS];
  logic [POS_W-1:0]  slot_pos    [TASKS];
  logic [CNT_W-1:0]  lvl_depth   [LEVELS];
  logic [TASK_W-1:0] cur_task;
  logic              cur_valid;
  logic [TASK_W-1:0] idle_slot;

  command_beat_t command_backlog [$];
  result_beat_t  due_results [$];
  int            commands_queued = 0;
  int            commands_taken  = 0;
  int            mismatch_count  = 0;
  int            quiet_cycles    = 0;

  logic          cmd_taken = 1'b0;
  logic          res_taken = 1'b0;
  logic          cfg_taken = 1'b0;
  int            send_wait = 0;
  int            recv_wait = 0;
  int            recv_draw;
  bit            recv_calm = 1'b0;
  command_beat_t head_beat;
  command_beat_t taken_beat;
  result_beat_t  want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // put a slot at the tail of a level
  function automatic void append_to_level(input logic [TASK_W-1:0] id,
                                          input logic [LVL_W-1:0] lv);
    slot_lvl[id] = lv;
    slot_pos[id] = POS_W'(lvl_depth[lv]);
    lvl_depth[lv] = lvl_depth[lv] + 1'b1;
  endfunction

  // take a slot out of its level, closing the gap behind it
  function automatic void pull_from_level(input logic [TASK_W-1:0] id);
    logic [LVL_W-1:0] lv;
    logic [POS_W-1:0] p;
    lv = slot_lvl[id];
    p  = slot_pos[id];
    for (int i = 0; i < TASKS; i++)
      if (i != id && slot_in_use[i] && slot_lvl[i] == lv && slot_pos[i] > p)
        slot_pos[i] = slot_pos[i] - 1'b1;
    if (lvl_depth[lv] != 0) lvl_depth[lv] = lvl_depth[lv] - 1'b1;
  endfunction

  // advance the scheduler image by one command and return the result it yields
  function automatic result_beat_t apply_command(input command_beat_t b);
    result_beat_t      r;
    logic [LVL_W-1:0]  lv;
    logic [TASK_W-1:0] id;
    logic [TASK_W-1:0] best;
    logic [TASK_W-1:0] nxt;
    logic              decide;
    logic              found;
    logic              cur_exec;
    int                best_pos;
    r      = '0;
    decide = 1'b0;
    id     = b.task_id;
    lv     = (int'(b.priority_req) < LEVELS) ? b.priority_req : LVL_W'(LEVELS - 1);
    case (b.command)
      CMD_ADD: begin
        if (slot_in_use[id]) begin
          r.status = STAT_ABSENT;
        end else begin
          slot_in_use[id] = 1'b1;
          slot_state[id]  = RUN_READY;
          append_to_level(id, lv);
        end
      end
      CMD_REMOVE: begin
        if (!slot_in_use[id]) begin
          r.status = STAT_ABSENT;
        end else begin
          pull_from_level(id);
          slot_in_use[id] = 1'b0;
        end
      end
      CMD_CHANGE: begin
        if (!slot_in_use[id]) begin
          r.status = STAT_ABSENT;
        end else if (slot_lvl[id] != lv) begin
          pull_from_level(id);
          append_to_level(id, lv);
        end
      end
      CMD_SCHED: decide = 1'b1;
      CMD_BLOCK: begin
        if (!cur_valid) begin
          r.status = STAT_NO_CUR;
        end else begin
          if (slot_in_use[cur_task]) slot_state[cur_task] = b.new_state;
          decide = 1'b1;
        end
      end
      CMD_UNBLOCK: begin
        if (!slot_in_use[id]) begin
          r.status = STAT_ABSENT;
        end else begin
          slot_state[id] = RUN_READY;
          decide = 1'b1;
        end
      end
      default: ;
    endcase

    if (decide) begin
      r.from_task  = cur_task;
      r.prev_valid = cur_valid;
      // first ready slot, most urgent level first, queue order within it
      found = 1'b0;
      best  = '0;
      for (int l = 0; l < LEVELS && !found; l++) begin
        best_pos = TASKS;
        for (int i = 0; i < TASKS; i++)
          if (slot_in_use[i] && slot_lvl[i] == l && slot_state[i] == RUN_READY &&
              slot_pos[i] < best_pos) begin
            best_pos = slot_pos[i];
            best     = TASK_W'(i);
            found    = 1'b1;
          end
      end
      cur_exec = cur_valid && slot_in_use[cur_task] && slot_state[cur_task] == RUN_EXEC;
      if (!found) begin
        nxt = idle_slot;
      end else begin
        nxt = best;
        // an executing task at a strictly more urgent level keeps the cpu
        if (cur_exec && slot_lvl[cur_task] < slot_lvl[best]) nxt = cur_task;
      end
      if (cur_exec) slot_state[cur_task] = RUN_READY;
      cur_task  = nxt;
      cur_valid = 1'b1;
      if (slot_in_use[nxt] && slot_state[nxt] == RUN_READY) slot_state[nxt] = RUN_EXEC;
      r.switched = 1'b1;
    end
    r.to_task = cur_task;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  // beats on all three channels, result check, command prediction, watchdog
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken    <= 1'b0;
      res_taken    <= 1'b0;
      cfg_taken    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      res_taken <= res_ch.valid && res_ch.ready;
      cfg_taken <= cfg_ch.valid && cfg_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat expected none, got status %0d to_task %0d",
                   $time, res_ch.status, res_ch.to_task);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 8'(want.status), 8'(res_ch.status));
          check_field("from_task", 8'(want.from_task), 8'(res_ch.from_task));
          check_field("prev_valid", 8'(want.prev_valid), 8'(res_ch.prev_valid));
          check_field("to_task", 8'(want.to_task), 8'(res_ch.to_task));
          check_field("switched", 8'(want.switched), 8'(res_ch.switched));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken_beat              = '0;
        taken_beat.command      = cmd_ch.command;
        taken_beat.task_id      = cmd_ch.task_id;
        taken_beat.priority_req = cmd_ch.priority_req;
        taken_beat.new_state    = cmd_ch.new_state;
        due_results.push_back(apply_command(taken_beat));
        commands_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready) idle_slot = cfg_ch.idle_slot_id;
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("multilevel_priority_task_scheduler: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // command driver: lead gap per beat, optional drain before a beat
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (command_backlog.size() == 0 ||
          (command_backlog[0].drain_first && due_results.size() != 0)) begin
        cmd_ch.valid <= 1'b0;
      end else if (send_wait < int'(command_backlog[0].lead_gap)) begin
        send_wait    <= send_wait + 1;
        cmd_ch.valid <= 1'b0;
      end else begin
        head_beat           = command_backlog.pop_front();
        send_wait           <= 0;
        cmd_ch.command      <= head_beat.command;
        cmd_ch.task_id      <= head_beat.task_id;
        cmd_ch.priority_req <= head_beat.priority_req;
        cmd_ch.new_state    <= head_beat.new_state;
        cmd_ch.valid        <= 1'b1;
      end
    end
  end

  // result ready: stall counts down only while a result is offered
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (res_taken) begin
      if ($urandom_range(0, 47) == 0) recv_calm = !recv_calm;
      recv_draw = recv_calm ? 0 : int'($urandom_range(0, 15));
      recv_wait    <= recv_draw;
      res_ch.ready <= (recv_draw == 0);
    end else if (recv_wait == 0) begin
      res_ch.ready <= 1'b1;
    end else begin
      if (res_ch.valid) recv_wait <= recv_wait - 1;
      res_ch.ready <= res_ch.valid && recv_wait == 1;
    end
  end

  function automatic void queue_command(input logic [CMD_W-1:0] c,
                                        input logic [TASK_W-1:0] id,
                                        input logic [LVL_W-1:0] p,
                                        input logic [RUN_W-1:0] ns,
                                        input bit calm, input bit drain);
    command_beat_t b;
    b.command      = c;
    b.task_id      = id;
    b.priority_req = p;
    b.new_state    = ns;
    b.lead_gap     = calm ? 4'd0 : 4'($urandom_range(0, 15));
    b.drain_first  = drain;
    command_backlog.push_back(b);
    commands_queued++;
  endfunction

  // random traffic over a small working set of slots that changes every chunk
  function automatic void queue_random_phase(input logic [TASK_W-1:0] idle_pick,
                                             input int count);
    logic [TASK_W-1:0] pool [8];
    bit                calm;
    int                roll;
    logic [CMD_W-1:0]  c;
    logic [TASK_W-1:0] id;
    logic [RUN_W-1:0]  ns;
    calm = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        foreach (pool[k]) pool[k] = TASK_W'($urandom_range(0, TASKS - 1));
        pool[0] = idle_pick;
      end
      roll = $urandom_range(0, 99);
      if (roll < 22)      c = CMD_ADD;
      else if (roll < 37) c = CMD_REMOVE;
      else if (roll < 50) c = CMD_CHANGE;
      else if (roll < 68) c = CMD_SCHED;
      else if (roll < 83) c = CMD_BLOCK;
      else if (roll < 97) c = CMD_UNBLOCK;
      else                c = roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
      id = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 7)]
                                      : TASK_W'($urandom_range(0, TASKS - 1));
      ns = ($urandom_range(0, 2) == 0) ? RUN_W'($urandom_range(0, 15))
                                       : RUN_W'($urandom_range(0, 2));
      queue_command(c, id, LVL_W'($urandom_range(0, LEVELS - 1)), ns, calm,
                    (n == 100) || ($urandom_range(0, 149) == 0));
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (commands_taken != commands_queued || due_results.size() != 0);
  endtask

  task automatic write_idle_slot(input logic [TASK_W-1:0] v);
    @(negedge clk);
    cfg_ch.idle_slot_id <= v;
    cfg_ch.valid        <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    // known values on every input from the start
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_ADD;
    cmd_ch.task_id      = '0;
    cmd_ch.priority_req = '0;
    cmd_ch.new_state    = '0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.idle_slot_id = '0;
    foreach (slot_in_use[i]) begin
      slot_in_use[i] = 1'b0;
      slot_state[i]  = '0;
      slot_lvl[i]    = '0;
      slot_pos[i]    = '0;
    end
    foreach (lvl_depth[l]) lvl_depth[l] = '0;
    cur_task  = '0;
    cur_valid = 1'b0;
    idle_slot = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_idle_slot(TASK_W'(TASKS - 1));

    // directed: corner slots and levels, every command, absent and duplicate slots
    queue_command(CMD_BLOCK,   6'd0,  3'd0, 4'd0,  1'b0, 1'b0); // no running task yet
    queue_command(CMD_SCHED,   6'd0,  3'd0, 4'd0,  1'b0, 1'b0); // idle slot, not present
    queue_command(CMD_ADD,     6'd63, 3'd7, 4'd0,  1'b0, 1'b0);
    queue_command(CMD_ADD,     6'd0,  3'd0, 4'd0,  1'b1, 1'b0);
    queue_command(CMD_ADD,     6'd0,  3'd3, 4'd0,  1'b1, 1'b0); // already present
    queue_command(CMD_REMOVE,  6'd5,  3'd0, 4'd0,  1'b0, 1'b0); // absent
    queue_command(CMD_CHANGE,  6'd5,  3'd2, 4'd0,  1'b0, 1'b0); // absent
    queue_command(CMD_UNBLOCK, 6'd5,  3'd0, 4'd0,  1'b0, 1'b0); // absent
    queue_command(CMD_SCHED,   6'd0,  3'd0, 4'd0,  1'b1, 1'b0);
    queue_command(CMD_ADD,     6'd1,  3'd0, 4'd0,  1'b1, 1'b0);
    queue_command(CMD_ADD,     6'd2,  3'd0, 4'd0,  1'b1, 1'b0);
    queue_command(CMD_ADD,     6'd3,  3'd3, 4'd0,  1'b0, 1'b0);
    queue_command(CMD_SCHED,   6'd0,  3'd0, 4'd0,  1'b0, 1'b0); // same level, no keep
    queue_command(CMD_CHANGE,  6'd3,  3'd3, 4'd0,  1'b0, 1'b0); // same level
    queue_command(CMD_CHANGE,  6'd1,  3'd5, 4'd0,  1'b0, 1'b0); // running task moved
    queue_command(CMD_SCHED,   6'd0,  3'd0, 4'd0,  1'b1, 1'b0);
    queue_command(CMD_BLOCK,   6'd0,  3'd0, 4'd15, 1'b0, 1'b0); // state above 8
    queue_command(CMD_BLOCK,   6'd0,  3'd0, 4'd0,  1'b0, 1'b0); // blocked as executing
    queue_command(CMD_UNBLOCK, 6'd0,  3'd0, 4'd0,  1'b0, 1'b0);
    queue_command(CMD_REMOVE,  6'd0,  3'd0, 4'd0,  1'b0, 1'b0); // running slot, queue head
    queue_command(CMD_SCHED,   6'd0,  3'd0, 4'd0,  1'b0, 1'b0);
    queue_command(CMD_SPARE_6, 6'd63, 3'd7, 4'd15, 1'b1, 1'b0);
    queue_command(CMD_SPARE_7, 6'd0,  3'd0, 4'd0,  1'b1, 1'b0);
    queue_command(CMD_BLOCK,   6'd0,  3'd0, 4'd2,  1'b0, 1'b0); // stopped
    queue_command(CMD_BLOCK,   6'd0,  3'd0, 4'd8,  1'b0, 1'b0);

    // random phases, each under its own idle slot
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      repeat (SETTLE) @(negedge clk);
      case (p)
        0:       write_idle_slot('0);
        1:       write_idle_slot(TASK_W'(TASKS - 1));
        default: write_idle_slot(TASK_W'($urandom_range(0, TASKS - 1)));
      endcase
      queue_random_phase(idle_slot, PHASE_ITEMS);
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("multilevel_priority_task_scheduler: match");
    end else begin
      $display("multilevel_priority_task_scheduler: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mpts_pkg.sv
rtl/mpts_if.sv
rtl/mpts_slot_ram.sv
rtl/mpts_cmp_unit.sv
rtl/multilevel_priority_task_scheduler.sv
rtl/mpts_checker.sv
dv/tb_multilevel_priority_task_scheduler.sv
